// ===== design/semt_pkg.sv =====
// Shared types, register indexes and arithmetic constants of the edge detector.
package semt_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 2048;
  localparam int CFG_W = 12;
  localparam int ROW_W = 13;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BLUR_ENABLE  = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  // Gray weights in hundredths.
  localparam logic [14:0] GRAY_W0 = 15'd11;
  localparam logic [14:0] GRAY_W1 = 15'd59;
  localparam logic [14:0] GRAY_W2 = 15'd30;

  // Reciprocal multipliers: floor(x / 100) for x below 25501, floor(x / 9) for x below 2296.
  localparam logic [27:0] DIV100_MUL   = 28'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [22:0] DIV9_MUL     = 23'd1821;
  localparam int          DIV9_SHIFT   = 14;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  // Compare-exchange network that leaves the median of nine in position four.
  localparam int MED_A [19] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int MED_B [19] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  typedef logic [8:0][7:0] win_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_c0;
    logic [7:0] pixel_c1;
    logic [7:0] pixel_c2;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       last_of_frame;
  } edge_word_t;

endpackage

// ===== design/semt_stream_if.sv =====
// Valid/ready stream channel that carries one word per handshake.
interface semt_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== design/sobel_edge_median_threshold.sv =====
// Streaming 3x3 Sobel edge detector with median threshold and optional box blur.
// Throughput: one word per clock; the whole pipeline halts only while a result waits unread.
// Latency: a result reaches the output register through the stage A to E registers once the word that
// completes its window is taken, which is W+1 words after its own pixel, or 2W+2 words with blur enabled.
// Reset clears counters, windows, pipeline valids and the registers (640, 480, blur off);
// the line memories are not cleared and need no clearing pass.
module sobel_edge_median_threshold import semt_pkg::*; #(
  parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  semt_stream_if.sink       pixels,
  semt_stream_if.source     edges,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // Column index width, effective width range and slot arithmetic width.
  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int SW = ROW_W + WW + 1;

  // Per-word control that rides along the pipeline, decided when the word is taken.
  typedef struct packed {
    logic          do_blur;
    logic          blur_inner;
    logic          blur_sel;
    logic          do_out;
    logic          edge_ok;
    logic          last;
    logic [CW-1:0] bcol;
  } ctl_t;

  function automatic logic [7:0] median9(input win_t w);
    win_t       p;
    logic [7:0] t;
    p = w;
    for (int i = 0; i < 19; i++) begin
      if (p[MED_A[i]] > p[MED_B[i]]) begin
        t = p[MED_A[i]];
        p[MED_A[i]] = p[MED_B[i]];
        p[MED_B[i]] = t;
      end
    end
    return p[4];
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             blur_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
      blur_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_BLUR_ENABLE:  blur_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective frame size: the width is held between three and the line memory size, the height raised to three.
  logic [WW-1:0]    w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [ROW_W-1:0] h_row;

  always_comb begin
    if (frame_width < CFG_W'(3)) begin
      w_eff = WW'(3);
    end else if (32'(frame_width) > MAX_LINE_WIDTH) begin
      w_eff = WW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height < CFG_W'(3)) ? CFG_W'(3) : frame_height;
    h_row = ROW_W'(h_eff);
  end

  // The whole pipeline advances whenever the output register is free or being read.
  // The input is held off while reset is applied.
  logic en;
  logic accept;
  assign en           = !edges.valid || edges.ready;
  assign pixels.ready = en && !rst;
  assign accept       = pixels.valid && pixels.ready;

  // Position counters of the next input slot and of the next result.
  logic [CW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;
  logic [CW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;

  // Decisions for the word at the input, from the counters, the current registers and the word's mode bit.
  logic          s0_in_frame;
  logic          s0_process;
  logic [SW-1:0] s0_slot;
  logic [SW-1:0] s0_lag;
  logic [14:0]   s0_sum;
  logic [WW-1:0] in_col_inc;
  logic [WW-1:0] out_col_inc;
  logic          in_wrap;
  logic          out_wrap;
  ctl_t          s0_ctl;

  always_comb begin
    s0_in_frame = in_row < h_row;
    s0_process  = !(s0_in_frame && pixels.data.mode);
    s0_slot     = SW'(in_row) * SW'(w_eff) + SW'(in_col);
    s0_lag      = blur_enable ? (SW'(w_eff) + SW'(w_eff) + SW'(2)) : (SW'(w_eff) + SW'(1));
    if (s0_in_frame) begin
      s0_sum = GRAY_W0 * 15'(pixels.data.pixel_c0) + GRAY_W1 * 15'(pixels.data.pixel_c1)
             + GRAY_W2 * 15'(pixels.data.pixel_c2);
    end else begin
      s0_sum = '0;
    end
    in_col_inc  = WW'(in_col) + WW'(1);
    out_col_inc = WW'(out_col) + WW'(1);
    in_wrap     = in_col_inc >= w_eff;
    out_wrap    = out_col_inc >= w_eff;

    s0_ctl.do_blur    = blur_enable && (s0_slot >= SW'(w_eff) + SW'(1));
    s0_ctl.blur_inner = (in_row >= ROW_W'(2)) && (in_row <= h_row - ROW_W'(1))
                     && (in_col >= CW'(2)) && (WW'(in_col) <= w_eff - WW'(1));
    s0_ctl.blur_sel   = blur_enable;
    s0_ctl.do_out     = s0_slot >= s0_lag;
    s0_ctl.edge_ok    = (out_row >= ROW_W'(1)) && (out_row <= h_row - ROW_W'(2))
                     && (out_col >= CW'(1)) && (WW'(out_col) <= w_eff - WW'(2));
    s0_ctl.last       = (out_row >= h_row - ROW_W'(1)) && (WW'(out_col) >= w_eff - WW'(1));
    s0_ctl.bcol       = (in_col != '0) ? (in_col - CW'(1)) : CW'(w_eff - WW'(1));
  end

  // The result flagged last of frame sends all four counters back to the frame origin.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept && s0_process) begin
      if (s0_ctl.do_out && s0_ctl.last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (s0_ctl.do_out) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= CW'(out_col_inc);
          end
        end
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= CW'(in_col_inc);
        end
      end
    end
  end

  // Stage A: gray value, gray line memories and gray window.
  logic          a_v;
  ctl_t          a_ctl;
  logic [14:0]   a_sum;
  logic [CW-1:0] a_col;
  logic [7:0]    gm_q;
  logic [7:0]    gt_q;
  logic [27:0]   a_prod;
  logic [7:0]    a_g;
  logic [7:0]    gray_mid [MAX_LINE_WIDTH];
  logic [7:0]    gray_top [MAX_LINE_WIDTH];
  win_t          gray_win;

  assign a_prod = 28'(a_sum) * DIV100_MUL;
  assign a_g    = 8'(a_prod >> DIV100_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum <= s0_sum;
      a_col <= in_col;
      a_ctl <= s0_ctl;
      gm_q  <= gray_mid[in_col];
      gt_q  <= gray_top[in_col];
      if (a_v) begin
        gray_mid[a_col] <= a_g;
        gray_top[a_col] <= gm_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v      <= 1'b0;
      gray_win <= '0;
    end else if (en) begin
      a_v <= accept && s0_process;
      if (a_v) begin
        for (int k = 0; k < 3; k++) begin
          gray_win[k*3]   <= gray_win[k*3+1];
          gray_win[k*3+1] <= gray_win[k*3+2];
        end
        gray_win[2] <= gt_q;
        gray_win[5] <= gm_q;
        gray_win[8] <= a_g;
      end
    end
  end

  // Stage B: box blur of the updated gray window and read of the blur line memories.
  logic        b_v;
  ctl_t        b_ctl;
  logic [11:0] b_sum;
  logic [22:0] b_prod;
  logic [7:0]  b_bval;

  always_comb begin
    b_sum = '0;
    for (int k = 0; k < 9; k++) begin
      b_sum = b_sum + 12'(gray_win[k]);
    end
    b_prod = 23'(b_sum) * DIV9_MUL;
    b_bval = b_ctl.blur_inner ? 8'(b_prod >> DIV9_SHIFT) : 8'd0;
  end

  // Stage C: blur line memories and blur window; the gray window is delayed to match.
  logic       c_v;
  ctl_t       c_ctl;
  logic [7:0] c_bval;
  logic [7:0] bm_q;
  logic [7:0] bt_q;
  logic [7:0] blur_mid [MAX_LINE_WIDTH];
  logic [7:0] blur_top [MAX_LINE_WIDTH];
  win_t       blur_win;
  win_t       gd1;
  win_t       gd2;

  always_ff @(posedge clk) begin
    if (en) begin
      b_ctl  <= a_ctl;
      c_ctl  <= b_ctl;
      c_bval <= b_bval;
      gd1    <= gray_win;
      gd2    <= gd1;
      bm_q   <= blur_mid[b_ctl.bcol];
      bt_q   <= blur_top[b_ctl.bcol];
      if (c_v && c_ctl.do_blur) begin
        blur_mid[c_ctl.bcol] <= c_bval;
        blur_top[c_ctl.bcol] <= bm_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v      <= 1'b0;
      c_v      <= 1'b0;
      blur_win <= '0;
    end else if (en) begin
      b_v <= a_v;
      c_v <= b_v;
      if (c_v && c_ctl.do_blur) begin
        for (int k = 0; k < 3; k++) begin
          blur_win[k*3]   <= blur_win[k*3+1];
          blur_win[k*3+1] <= blur_win[k*3+2];
        end
        blur_win[2] <= bt_q;
        blur_win[5] <= bm_q;
        blur_win[8] <= c_bval;
      end
    end
  end

  // Stage D: Sobel gradients and window median.
  logic               d_v;
  ctl_t               d_ctl;
  win_t               d_win;
  logic signed [10:0] d_gx;
  logic signed [10:0] d_gy;
  logic [7:0]         d_med;

  always_comb begin
    d_win = d_ctl.blur_sel ? blur_win : gd2;
    d_gx  = (11'(d_win[0]) + 11'({d_win[3], 1'b0}) + 11'(d_win[6]))
          - (11'(d_win[2]) + 11'({d_win[5], 1'b0}) + 11'(d_win[8]));
    d_gy  = (11'(d_win[0]) + 11'({d_win[1], 1'b0}) + 11'(d_win[2]))
          - (11'(d_win[6]) + 11'({d_win[7], 1'b0}) + 11'(d_win[8]));
    d_med = median9(d_win);
  end

  // Stage E: squared magnitude against squared median.
  logic               e_v;
  logic               e_do_out;
  logic               e_edge_ok;
  logic               e_last;
  logic signed [10:0] e_gx;
  logic signed [10:0] e_gy;
  logic [7:0]         e_med;
  logic signed [21:0] e_sqx;
  logic signed [21:0] e_sqy;
  logic [20:0]        e_mag;
  logic [15:0]        e_thr;
  logic               e_hit;

  always_comb begin
    e_sqx = e_gx * e_gx;
    e_sqy = e_gy * e_gy;
    e_mag = e_sqx[20:0] + e_sqy[20:0];
    e_thr = 16'(e_med) * 16'(e_med);
    e_hit = e_mag > 21'(e_thr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ctl     <= c_ctl;
      e_gx      <= d_gx;
      e_gy      <= d_gy;
      e_med     <= d_med;
      e_do_out  <= d_ctl.do_out;
      e_edge_ok <= d_ctl.edge_ok;
      e_last    <= d_ctl.last;
    end
  end

  // Output register: out_valid is set only for slots that carry a result.
  logic       out_valid;
  edge_word_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v       <= 1'b0;
      e_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      d_v       <= c_v;
      e_v       <= d_v;
      out_valid <= e_v && e_do_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.edge_value    <= (e_hit && e_edge_ok) ? EDGE_ON : EDGE_OFF;
      out_word.last_of_frame <= e_last;
    end
  end

  assign edges.valid = out_valid;
  assign edges.data  = out_word;

  // A flush word during the pixel phase must not enter the pipeline.
  a_flush_ignored : assert property (@(posedge clk) disable iff (rst)
    (accept && s0_in_frame && pixels.data.mode) |=> !a_v)
    else $error("flush word during pixel phase entered the pipeline");

  // The word that yields the last result of a frame returns all counters to the origin.
  a_frame_restart : assert property (@(posedge clk) disable iff (rst)
    (accept && s0_process && s0_ctl.do_out && s0_ctl.last) |=>
      (in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0))
    else $error("counters not cleared after last result of frame");

  // A new result appears only from a result-carrying word in the last stage.
  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(e_v && e_do_out))
    else $error("output word without a result-carrying slot");

endmodule

// ===== tb/sobel_edge_median_threshold_test.sv =====
// Self-checking testbench for the streaming Sobel edge detector with median threshold.
`timescale 1ns / 1ps

module sobel_edge_median_threshold_test;
  import semt_pkg::*;

  localparam int LINE_MAX = MAX_LINE_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_WORDS = 1000;

  // Kinds of directed rows: a register write, or a word whose result is either worked out
  // by the predictor or typed in because it can be read off at a glance.
  typedef enum logic [2:0] {
    ROW_CFG,
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_BORDER,
    ROW_BORDER_LAST
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_index;
    logic [11:0] reg_value;
    pixel_word_t word;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  semt_stream_if #(.word_t(pixel_word_t)) pixel_ch ();
  semt_stream_if #(.word_t(edge_word_t)) edge_ch ();

  sobel_edge_median_threshold dut (
    .clk(clk),
    .rst(rst),
    .pixels(pixel_ch.sink),
    .edges(edge_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: register copies, two-line stores and 3x3 windows for the gray
  // plane (index 0) and the blurred plane (index 1), and the four position counters.
  int unsigned width_reg, height_reg, blur_reg;
  byte unsigned line_mem [2][2*LINE_MAX];
  byte unsigned window [2][9];
  int unsigned in_col, in_row, out_col, out_row;

  edge_word_t expected_edges [$];
  int mismatch_count;
  int accepted_words;
  int unsigned cycle_count;
  bit hold_request;

  // Append one expected result word at the tail of the queue.
  function automatic void note_expected(edge_word_t e);
    expected_edges = {expected_edges, e};
  endfunction

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  // Shift a new column into one plane's window, rotating the two-line store.
  function automatic void shift_column(int plane, int unsigned col, byte unsigned v);
    byte unsigned top, mid;
    if (col >= LINE_MAX) col = LINE_MAX - 1;
    top = line_mem[plane][LINE_MAX + col];
    mid = line_mem[plane][col];
    line_mem[plane][LINE_MAX + col] = mid;
    line_mem[plane][col] = v;
    for (int k = 0; k < 3; k++) begin
      window[plane][k*3] = window[plane][k*3+1];
      window[plane][k*3+1] = window[plane][k*3+2];
    end
    window[plane][2] = top;
    window[plane][5] = mid;
    window[plane][8] = v;
  endfunction

  function automatic int median_of_window(int plane);
    byte unsigned s [9];
    byte unsigned t;
    for (int i = 0; i < 9; i++) s[i] = window[plane][i];
    for (int i = 0; i < 9; i++)
      for (int j = 0; j < 8 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
    return int'(s[4]);
  endfunction

  // Gradient energy against the squared median, which stands in for the square root.
  function automatic logic [7:0] edge_decision(int plane);
    int gx, gy, m;
    gx = (window[plane][0] + 2*window[plane][3] + window[plane][6])
       - (window[plane][2] + 2*window[plane][5] + window[plane][8]);
    gy = (window[plane][0] + 2*window[plane][1] + window[plane][2])
       - (window[plane][6] + 2*window[plane][7] + window[plane][8]);
    m = median_of_window(plane);
    return (gx*gx + gy*gy > m*m) ? EDGE_ON : EDGE_OFF;
  endfunction

  // Advance the predictor by one accepted word. Returns 0 when the word is ignored.
  function automatic bit predict_edge(pixel_word_t w, output bit produced,
                                      output edge_word_t res);
    int unsigned wd, ht, slot, lag, bcol, sum;
    bit in_frame, last;
    byte unsigned gray, bv;
    logic [7:0] ev;
    wd = active_width();
    ht = active_height();
    in_frame = in_row < ht;
    slot = in_row * wd + in_col;
    lag = blur_reg ? 2*wd + 2 : wd + 1;
    produced = 0;
    res = '0;
    gray = 0;
    if (in_frame && w.mode) return 0;
    if (in_frame)
      gray = 8'((11*int'(w.pixel_c0) + 59*int'(w.pixel_c1) + 30*int'(w.pixel_c2)) / 100);
    shift_column(0, in_col, gray);
    if (blur_reg && slot >= wd + 1) begin
      bv = 0;
      bcol = (in_col >= 1) ? in_col - 1 : wd - 1;
      if (in_row >= 2 && in_row <= ht - 1 && in_col >= 2 && in_col <= wd - 1) begin
        sum = 0;
        for (int k = 0; k < 9; k++) sum += window[0][k];
        bv = 8'(sum / 9);
      end
      shift_column(1, bcol, bv);
    end
    if (slot >= lag) begin
      ev = EDGE_OFF;
      last = (out_row >= ht - 1) && (out_col >= wd - 1);
      if (out_row >= 1 && out_row <= ht - 2 && out_col >= 1 && out_col <= wd - 2)
        ev = edge_decision(blur_reg ? 1 : 0);
      res.edge_value = ev;
      res.last_of_frame = last;
      produced = 1;
      if (last) begin
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        return 1;
      end
      out_col++;
      if (out_col >= wd) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= wd) begin
      in_col = 0;
      in_row++;
    end
    return 1;
  endfunction

  // Clock and the single reset pulse at the start of the run.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    pixel_ch.valid = 0;
    pixel_ch.data = '0;
    edge_ch.ready = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: ready follows a pattern that is redrawn at random, from always
  // ready to sparse. One long hold-off lets the pipeline fill and push back on the input.
  initial begin : receiver
    int pattern, span, hold_left, phase;
    cycle_count = 0;
    hold_left = 0;
    pattern = 0;
    span = 0;
    phase = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (span == 0) begin
        pattern = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
      end
      span--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        edge_ch.ready <= 0;
      end else begin
        case (pattern)
          0: edge_ch.ready <= 1;
          1: edge_ch.ready <= ($urandom_range(0, 1) == 1);
          2: edge_ch.ready <= (phase % 4 != 0);
          default: edge_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
      @(negedge clk);
    end
  end

  // Result checker: every accepted result word is compared with the oldest expectation.
  always @(posedge clk) begin
    edge_word_t want;
    if (!rst && edge_ch.valid && edge_ch.ready) begin
      if (expected_edges.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result word: edge %0d last %0b",
                   edge_ch.data.edge_value, edge_ch.data.last_of_frame);
      end else begin
        want = expected_edges.pop_front();
        if (edge_ch.data.edge_value !== want.edge_value ||
            edge_ch.data.last_of_frame !== want.last_of_frame) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected edge %0d last %0b, got edge %0d last %0b",
                     want.edge_value, want.last_of_frame,
                     edge_ch.data.edge_value, edge_ch.data.last_of_frame);
        end
      end
    end
  end

  // Sender state for bursts: words left in the current burst before a gap.
  int burst_left;

  // Offer one pixel word and hold it until it is taken. The expectation is queued at the
  // accepting edge; a directed row may replace the predicted result by a typed one.
  task automatic send_word(pixel_word_t w, row_kind_t kind = ROW_PREDICT);
    bit produced, counted;
    edge_word_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        pixel_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    pixel_ch.valid <= 1;
    pixel_ch.data <= w;
    do @(posedge clk); while (!pixel_ch.ready);
    counted = predict_edge(w, produced, res);
    if (counted) accepted_words++;
    case (kind)
      ROW_BORDER: res = '{edge_value: EDGE_OFF, last_of_frame: 1'b0};
      ROW_BORDER_LAST: res = '{edge_value: EDGE_OFF, last_of_frame: 1'b1};
      default: ;
    endcase
    if (kind == ROW_NO_RESULT) begin
      if (produced) note_expected(res);
    end else if (produced || kind != ROW_PREDICT) begin
      note_expected(res);
    end
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle so that
  // register writes land on an idle block.
  task automatic drain_to_idle();
    pixel_ch.valid <= 0;
    while (expected_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [11:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH: width_reg = 32'(value);
      REG_FRAME_HEIGHT: height_reg = 32'(value);
      default: blur_reg = 32'(value[0]);
    endcase
    @(negedge clk);
  endtask

  task automatic configure(logic [11:0] w, logic [11:0] h, logic b);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BLUR_ENABLE, {11'd0, b});
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic pixel_word_t random_pixel();
    pixel_word_t p;
    p.mode = 0;
    p.pixel_c0 = 8'($urandom_range(0, 255));
    p.pixel_c1 = 8'($urandom_range(0, 255));
    p.pixel_c2 = 8'($urandom_range(0, 255));
    return p;
  endfunction

  // One frame: W*H pixels with stray flush words mixed in (ignored by the block), then the
  // drain slots, some of them carried by pixel words whose channels are dropped. The image is
  // either noise or two flat regions split at a random column, so that both flat windows and
  // real edges show up.
  task automatic send_frame(bit blocky);
    int unsigned wd, ht, lag, split;
    pixel_word_t p, left_px, right_px, flush_w;
    wd = active_width();
    ht = active_height();
    lag = blur_reg ? 2*wd + 2 : wd + 1;
    split = $urandom_range(1, wd - 1);
    left_px = random_pixel();
    right_px = random_pixel();
    flush_w = random_pixel();
    flush_w.mode = 1;
    for (int r = 0; r < ht; r++)
      for (int c = 0; c < wd; c++) begin
        if ($urandom_range(0, 19) == 0) send_word(flush_w);
        if (blocky && $urandom_range(0, 7) != 0) p = (c < split) ? left_px : right_px;
        else p = random_pixel();
        send_word(p);
      end
    for (int k = 0; k < lag; k++) begin
      p = random_pixel();
      p.mode = ($urandom_range(0, 4) != 0);
      send_word(p);
    end
    // A stray flush right after the frame falls into the next frame's pixel phase.
    if ($urandom_range(0, 9) == 0) send_word(flush_w);
  endtask

  directed_row_t directed [$];

  // Table of directed rows: a 3x3 frame, where every result but the center one is a border
  // zero, with extreme channel values, a flush inside the pixel phase and a pixel word
  // inside the drain phase.
  task automatic build_table();
    pixel_word_t white, black, mixed, flush_w;
    white = '{mode: 1'b0, pixel_c0: 8'hFF, pixel_c1: 8'hFF, pixel_c2: 8'hFF};
    black = '0;
    mixed = '{mode: 1'b0, pixel_c0: 8'hFF, pixel_c1: 8'h00, pixel_c2: 8'hAA};
    flush_w = '{mode: 1'b1, pixel_c0: 8'h55, pixel_c1: 8'hFF, pixel_c2: 8'h00};
    directed = '{
      '{ROW_CFG, REG_FRAME_WIDTH, 12'd3, '0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 12'd3, '0},
      '{ROW_CFG, REG_BLUR_ENABLE, 12'd0, '0},
      '{ROW_NO_RESULT, REG_FRAME_WIDTH, '0, white},
      '{ROW_NO_RESULT, REG_FRAME_WIDTH, '0, black},
      '{ROW_NO_RESULT, REG_FRAME_WIDTH, '0, flush_w},
      '{ROW_NO_RESULT, REG_FRAME_WIDTH, '0, white},
      '{ROW_NO_RESULT, REG_FRAME_WIDTH, '0, mixed},
      '{ROW_BORDER, REG_FRAME_WIDTH, '0, black},
      '{ROW_BORDER, REG_FRAME_WIDTH, '0, white},
      '{ROW_BORDER, REG_FRAME_WIDTH, '0, black},
      '{ROW_BORDER, REG_FRAME_WIDTH, '0, mixed},
      '{ROW_PREDICT, REG_FRAME_WIDTH, '0, white},
      '{ROW_BORDER, REG_FRAME_WIDTH, '0, flush_w},
      '{ROW_BORDER, REG_FRAME_WIDTH, '0, mixed},
      '{ROW_BORDER, REG_FRAME_WIDTH, '0, flush_w},
      '{ROW_BORDER_LAST, REG_FRAME_WIDTH, '0, flush_w}
    };
  endtask

  initial begin : stimulus
    logic [11:0] wv, hv;
    width_reg = 32'(RESET_FRAME_WIDTH);
    height_reg = 32'(RESET_FRAME_HEIGHT);
    blur_reg = 0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    for (int p = 0; p < 2; p++)
      for (int i = 0; i < 2*LINE_MAX; i++) line_mem[p][i] = 0;
    for (int p = 0; p < 2; p++)
      for (int i = 0; i < 9; i++) window[p][i] = 0;
    mismatch_count = 0;
    accepted_words = 0;
    burst_left = 0;
    hold_request = 0;
    build_table();
    @(negedge clk);
    while (rst) @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_reg(directed[i].reg_index, directed[i].reg_value);
        cfg_we <= 0;
        @(negedge clk);
      end else begin
        send_word(directed[i].word, directed[i].kind);
      end
    end
    drain_to_idle();

    // Register extremes: width and height below range, a tall narrow frame and a wider
    // blurred one. Frames are kept small in the other dimension.
    configure(12'd0, 12'd0, 1'b1);
    send_frame(0);
    drain_to_idle();
    configure(12'd3, 12'd40, 1'b0);
    send_frame(1);
    drain_to_idle();
    configure(12'd24, 12'd3, 1'b1);
    send_frame(1);
    drain_to_idle();
    configure(12'd1, 12'd2, 1'b1);
    send_frame(1);
    drain_to_idle();

    // Random frames of small sizes. The receiver holds off once during the first one.
    accepted_words = 0;
    hold_request = 1;
    while (accepted_words < RANDOM_WORDS) begin
      wv = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 12));
      hv = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 8));
      configure(wv, hv, 1'($urandom_range(0, 1)));
      // Up to three frames back to back under one setting keep the line stores warm.
      repeat ($urandom_range(1, 3)) send_frame(1'($urandom_range(0, 1)));
      drain_to_idle();
    end

    if (mismatch_count == 0 && expected_edges.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/semt_pkg.sv
design/semt_stream_if.sv
design/sobel_edge_median_threshold.sv
tb/sobel_edge_median_threshold_test.sv
